>>> rtl/psds_pkg.sv
package psds_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int T_FRAC_BITS = 32;

  // where the projection landed
  typedef enum logic [1:0] {
    REGION_INSIDE = 2'd0,
    REGION_START  = 2'd1,
    REGION_END    = 2'd2
  } region_t;

endpackage

>>> rtl/psds_if.sv
interface psds_in_if #(
  parameter int CW = psds_pkg::COORD_WIDTH
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] point_lng;
  logic [CW-2:0] point_lat;
  logic [CW-1:0] start_lng;
  logic [CW-2:0] start_lat;
  logic [CW-1:0] end_lng;
  logic [CW-2:0] end_lat;

  modport source (output valid, point_lng, point_lat, start_lng, start_lat, end_lng, end_lat,
                  input ready);
  modport sink (input valid, point_lng, point_lat, start_lng, start_lat, end_lng, end_lat,
                output ready);
endinterface

interface psds_out_if #(
  parameter int TF = psds_pkg::T_FRAC_BITS
);
  logic        valid;
  logic        ready;
  logic [63:0] dist_sq;
  logic [TF:0] proj_param;
  logic [1:0]  proj_region;
  logic        saturated;

  modport source (output valid, dist_sq, proj_param, proj_region, saturated, input ready);
  modport sink (input valid, dist_sq, proj_param, proj_region, saturated, output ready);
endinterface

>>> rtl/psds_prep.sv
module psds_prep #(
  parameter int CW = psds_pkg::COORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [CW-1:0]         p_lng,
  input  logic [CW-2:0]         p_lat,
  input  logic [CW-1:0]         a_lng,
  input  logic [CW-2:0]         a_lat,
  input  logic [CW-1:0]         b_lng,
  input  logic [CW-2:0]         b_lat,
  output logic                  v_o,
  output logic signed [CW:0]    abx_o,
  output logic signed [CW:0]    aby_o,
  output logic signed [CW:0]    apx_o,
  output logic signed [CW:0]    apy_o,
  output logic [2*CW+2:0]       ab2_o,
  output logic signed [2*CW+2:0] dot_o
);
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic                 v0_r, v1_r, v2_r;
  logic signed [DW-1:0] abx0_r, aby0_r, apx0_r, apy0_r;
  logic signed [DW-1:0] abx1_r, aby1_r, apx1_r, apy1_r;
  logic signed [DW-1:0] abx2_r, aby2_r, apx2_r, apy2_r;
  logic signed [PW-1:0] xx_r, yy_r, dx_r, dy_r;
  logic [PW:0]          ab2_r;
  logic signed [PW:0]   dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abx0_r <= $signed({b_lng[CW-1], b_lng}) - $signed({a_lng[CW-1], a_lng});
      aby0_r <= $signed({{2{b_lat[CW-2]}}, b_lat}) - $signed({{2{a_lat[CW-2]}}, a_lat});
      apx0_r <= $signed({p_lng[CW-1], p_lng}) - $signed({a_lng[CW-1], a_lng});
      apy0_r <= $signed({{2{p_lat[CW-2]}}, p_lat}) - $signed({{2{a_lat[CW-2]}}, a_lat});

      xx_r   <= PW'(abx0_r) * PW'(abx0_r);
      yy_r   <= PW'(aby0_r) * PW'(aby0_r);
      dx_r   <= PW'(apx0_r) * PW'(abx0_r);
      dy_r   <= PW'(apy0_r) * PW'(aby0_r);
      abx1_r <= abx0_r;
      aby1_r <= aby0_r;
      apx1_r <= apx0_r;
      apy1_r <= apy0_r;

      ab2_r  <= {1'b0, xx_r} + {1'b0, yy_r};
      dot_r  <= $signed({dx_r[PW-1], dx_r}) + $signed({dy_r[PW-1], dy_r});
      abx2_r <= abx1_r;
      aby2_r <= aby1_r;
      apx2_r <= apx1_r;
      apy2_r <= apy1_r;
    end
  end

  assign v_o   = v2_r;
  assign abx_o = abx2_r;
  assign aby_o = aby2_r;
  assign apx_o = apx2_r;
  assign apy_o = apy2_r;
  assign ab2_o = ab2_r;
  assign dot_o = dot_r;

endmodule

>>> rtl/psds_div.sv
module psds_div #(
  parameter int CW = psds_pkg::COORD_WIDTH,
  parameter int TF = psds_pkg::T_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_i,
  input  logic signed [CW:0]     abx_i,
  input  logic signed [CW:0]     aby_i,
  input  logic signed [CW:0]     apx_i,
  input  logic signed [CW:0]     apy_i,
  input  logic [2*CW+2:0]        ab2_i,
  input  logic signed [2*CW+2:0] dot_i,
  output logic                   v_o,
  output logic signed [CW:0]     abx_o,
  output logic signed [CW:0]     aby_o,
  output logic signed [CW:0]     apx_o,
  output logic signed [CW:0]     apy_o,
  output logic [TF:0]            tq_o,
  output logic [1:0]             region_o
);
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int RW = PW + 2;

  logic                 v_r   [TF+1];
  logic [RW-1:0]        rem_r [TF+1];
  logic [TF-1:0]        q_r   [TF+1];
  logic [PW:0]          ab2_r [TF+1];
  logic signed [DW-1:0] abx_r [TF+1];
  logic signed [DW-1:0] aby_r [TF+1];
  logic signed [DW-1:0] apx_r [TF+1];
  logic signed [DW-1:0] apy_r [TF+1];
  logic [1:0]           reg_r [TF+1];
  logic                 byp_r [TF+1];
  logic [TF:0]          fix_r [TF+1];

  logic        seg_zero, dot_neg, dot_zero, dot_ge, dot_eq, byp_c;
  logic [TF:0] fix_c;
  logic [1:0]  reg_c;

  // classify the projection before the quotient is worked out
  always_comb begin
    seg_zero = (ab2_i == '0);
    dot_neg  = dot_i[PW];
    dot_zero = (dot_i == '0);
    dot_ge   = !dot_neg && ($unsigned(dot_i) >= ab2_i);
    dot_eq   = ($unsigned(dot_i) == ab2_i);
    byp_c    = seg_zero || dot_neg || dot_zero || dot_ge;
    fix_c    = '0;
    reg_c    = psds_pkg::REGION_INSIDE;
    if (seg_zero || dot_neg) begin
      reg_c = psds_pkg::REGION_START;
    end else if (dot_ge) begin
      fix_c = {1'b1, TF'(0)};
      reg_c = dot_eq ? psds_pkg::REGION_INSIDE : psds_pkg::REGION_END;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= byp_c ? '0 : RW'($unsigned(dot_i));
      q_r[0]   <= '0;
      ab2_r[0] <= ab2_i;
      abx_r[0] <= abx_i;
      aby_r[0] <= aby_i;
      apx_r[0] <= apx_i;
      apy_r[0] <= apy_i;
      reg_r[0] <= reg_c;
      byp_r[0] <= byp_c;
      fix_r[0] <= fix_c;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < TF; k++) begin : g_step
    logic [RW-1:0] rem_sh;
    logic          take;

    always_comb begin
      rem_sh = {rem_r[k][RW-2:0], 1'b0};
      take   = (rem_sh >= {1'b0, ab2_r[k]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? (rem_sh - {1'b0, ab2_r[k]}) : rem_sh;
        q_r[k+1]   <= {q_r[k][TF-2:0], take};
        ab2_r[k+1] <= ab2_r[k];
        abx_r[k+1] <= abx_r[k];
        aby_r[k+1] <= aby_r[k];
        apx_r[k+1] <= apx_r[k];
        apy_r[k+1] <= apy_r[k];
        reg_r[k+1] <= reg_r[k];
        byp_r[k+1] <= byp_r[k];
        fix_r[k+1] <= fix_r[k];
      end
    end
  end

  assign v_o      = v_r[TF];
  assign abx_o    = abx_r[TF];
  assign aby_o    = aby_r[TF];
  assign apx_o    = apx_r[TF];
  assign apy_o    = apy_r[TF];
  assign tq_o     = byp_r[TF] ? fix_r[TF] : {1'b0, q_r[TF]};
  assign region_o = reg_r[TF];

endmodule

>>> rtl/psds_dist.sv
module psds_dist #(
  parameter int CW = psds_pkg::COORD_WIDTH,
  parameter int TF = psds_pkg::T_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  logic signed [CW:0] abx_i,
  input  logic signed [CW:0] aby_i,
  input  logic signed [CW:0] apx_i,
  input  logic signed [CW:0] apy_i,
  input  logic [TF:0]        tq_i,
  input  logic [1:0]         region_i,
  output logic               v_o,
  output logic [63:0]        dist_o,
  output logic [TF:0]        tq_o,
  output logic [1:0]         region_o,
  output logic               sat_o
);
  localparam int DW  = CW + 1;
  localparam int MW  = DW + TF + 2;
  localparam int EW  = MW + 1;
  localparam int OW  = DW + 2;
  localparam int SQW = 2 * OW;
  localparam int SW  = (SQW + 1 > 65) ? SQW + 1 : 65;

  logic                 v1_r, v2_r, v3_r, v4_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic signed [DW-1:0] apx1_r, apy1_r;
  logic [OW-1:0]        ox_r, oy_r;
  logic [SQW-1:0]       sqx_r, sqy_r;
  logic [TF:0]          tq1_r, tq2_r, tq3_r, tq4_r;
  logic [1:0]           rg1_r, rg2_r, rg3_r, rg4_r;
  logic [63:0]          dist_r;
  logic                 sat_r;
  logic [SW-1:0]        sum;

  // |round(e / 2^TF)|, halves toward plus infinity
  function automatic logic [OW-1:0] off_mag(input logic signed [MW-1:0] m,
                                            input logic signed [DW-1:0] ap);
    logic signed [EW-1:0] e;
    logic signed [EW-1:0] r;
    logic signed [OW-1:0] rs;
    e  = EW'(m) - (EW'(ap) <<< TF) + (EW'(1) <<< (TF - 1));
    r  = e >>> TF;
    rs = r[OW-1:0];
    return rs[OW-1] ? OW'(-rs) : OW'(rs);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign sum = SW'(sqx_r) + SW'(sqy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r   <= MW'(abx_i) * MW'($signed({1'b0, tq_i}));
      my_r   <= MW'(aby_i) * MW'($signed({1'b0, tq_i}));
      apx1_r <= apx_i;
      apy1_r <= apy_i;
      tq1_r  <= tq_i;
      rg1_r  <= region_i;

      ox_r   <= off_mag(mx_r, apx1_r);
      oy_r   <= off_mag(my_r, apy1_r);
      tq2_r  <= tq1_r;
      rg2_r  <= rg1_r;

      sqx_r  <= SQW'(ox_r) * SQW'(ox_r);
      sqy_r  <= SQW'(oy_r) * SQW'(oy_r);
      tq3_r  <= tq2_r;
      rg3_r  <= rg2_r;

      sat_r  <= |sum[SW-1:64];
      dist_r <= (|sum[SW-1:64]) ? '1 : sum[63:0];
      tq4_r  <= tq3_r;
      rg4_r  <= rg3_r;
    end
  end

  assign v_o      = v4_r;
  assign dist_o   = dist_r;
  assign tq_o     = tq4_r;
  assign region_o = rg4_r;
  assign sat_o    = sat_r;

endmodule

>>> rtl/point_segment_distance_squared.sv
// Squared distance from a query point to a segment, fully pipelined.
// in_ch carries the point and the segment start/end; out_ch carries dist_sq,
// the clamped projection parameter (T_FRAC_BITS fraction bits), the region
// where the projection fell and a saturation flag. Both are valid/ready
// channels; a transaction completes when valid and ready are both high.
// Throughput: one transaction per cycle on each side while out_ch takes its results.
// Pipeline: 3 stages of differences/products/sums, 1 classify stage, one
// stage per quotient bit in the divider, 4 stages of offset multiply,
// rounding, squaring and sum.
// Stalls: the whole pipeline advances together; when out_ch holds a result
// that is not taken, in_ch.ready drops and every stage holds its contents,
// so nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits, the pipeline comes
// up empty and accepts input on the next cycle.
module point_segment_distance_squared #(
  parameter int COORD_WIDTH = psds_pkg::COORD_WIDTH,
  parameter int T_FRAC_BITS = psds_pkg::T_FRAC_BITS
) (
  input logic        clk,
  input logic        rst_n,
  psds_in_if.sink    in_ch,
  psds_out_if.source out_ch
);
  logic                        en;
  logic                        p_v, d_v, o_v;
  logic signed [COORD_WIDTH:0] p_abx, p_aby, p_apx, p_apy;
  logic signed [COORD_WIDTH:0] d_abx, d_aby, d_apx, d_apy;
  logic [2*COORD_WIDTH+2:0]    p_ab2;
  logic signed [2*COORD_WIDTH+2:0] p_dot;
  logic [T_FRAC_BITS:0]        d_tq;
  logic [1:0]                  d_region;

  assign en          = !o_v || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = o_v;

  psds_prep #(.CW(COORD_WIDTH)) u_prep (
    .clk, .rst_n, .en,
    .in_valid (in_ch.valid),
    .p_lng    (in_ch.point_lng),
    .p_lat    (in_ch.point_lat),
    .a_lng    (in_ch.start_lng),
    .a_lat    (in_ch.start_lat),
    .b_lng    (in_ch.end_lng),
    .b_lat    (in_ch.end_lat),
    .v_o      (p_v),
    .abx_o    (p_abx),
    .aby_o    (p_aby),
    .apx_o    (p_apx),
    .apy_o    (p_apy),
    .ab2_o    (p_ab2),
    .dot_o    (p_dot)
  );

  psds_div #(.CW(COORD_WIDTH), .TF(T_FRAC_BITS)) u_div (
    .clk, .rst_n, .en,
    .v_i      (p_v),
    .abx_i    (p_abx),
    .aby_i    (p_aby),
    .apx_i    (p_apx),
    .apy_i    (p_apy),
    .ab2_i    (p_ab2),
    .dot_i    (p_dot),
    .v_o      (d_v),
    .abx_o    (d_abx),
    .aby_o    (d_aby),
    .apx_o    (d_apx),
    .apy_o    (d_apy),
    .tq_o     (d_tq),
    .region_o (d_region)
  );

  psds_dist #(.CW(COORD_WIDTH), .TF(T_FRAC_BITS)) u_dist (
    .clk, .rst_n, .en,
    .v_i      (d_v),
    .abx_i    (d_abx),
    .aby_i    (d_aby),
    .apx_i    (d_apx),
    .apy_i    (d_apy),
    .tq_i     (d_tq),
    .region_i (d_region),
    .v_o      (o_v),
    .dist_o   (out_ch.dist_sq),
    .tq_o     (out_ch.proj_param),
    .region_o (out_ch.proj_region),
    .sat_o    (out_ch.saturated)
  );

endmodule

>>> rtl/psds_checker.sv
module psds_checker #(
  parameter int TF = psds_pkg::T_FRAC_BITS
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] dist_sq,
  input logic [TF:0] proj_param,
  input logic [1:0]  proj_region,
  input logic        saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_end_param: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && proj_region == psds_pkg::REGION_END |-> proj_param == {1'b1, TF'(0)})
    else $error("clamp at end without t = 1");

  a_start_param: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && proj_region == psds_pkg::REGION_START |-> proj_param == '0)
    else $error("clamp at start without t = 0");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> dist_sq == '1)
    else $error("saturated without full-scale distance");

endmodule

bind point_segment_distance_squared psds_checker #(.TF(T_FRAC_BITS)) u_psds_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .dist_sq     (out_ch.dist_sq),
  .proj_param  (out_ch.proj_param),
  .proj_region (out_ch.proj_region),
  .saturated   (out_ch.saturated)
);
